FILE: rtl/wbgc_pkg.sv
// wbgc_pkg: widths, register indexes, reset values and lane control type
// shared by the wrench bias / gravity compensation filter modules.
// No dependencies.
package wbgc_pkg;

  // field widths
  localparam int unsigned RAW_W    = 32;
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned WEIGHT_W = 25;
  localparam int unsigned COM_W    = 18;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // number of wrench axes and axis vector elements
  localparam int unsigned NUM_LANES = 6;
  localparam int unsigned NUM_AXIS  = 3;

  // internal arithmetic widths
  localparam int unsigned FPROD_W = WEIGHT_W + 1 + AXIS_W;  // weight times axis
  localparam int unsigned F_W     = 28;                     // load force
  localparam int unsigned XP_W    = COM_W + F_W;            // cross product term
  localparam int unsigned LD_W    = 30;                     // load wrench element
  localparam int unsigned ACC_W   = 40;                     // bias accumulator
  localparam int unsigned ASUM_W  = ACC_W + 2;              // accumulator update sum
  localparam int unsigned NUM_W   = ACC_W + 1;              // rounded magnitude, quotient
  localparam int unsigned W_W     = ACC_W + 1;              // compensated wrench
  localparam int unsigned K_W     = GAIN_W + 1;             // 65536 - gain
  localparam int unsigned GY_W    = GAIN_W + 1 + RAW_W;     // gain times filter state
  localparam int unsigned KW_W    = K_W + 1 + W_W;          // (1-gain) times wrench
  localparam int unsigned Y_W     = KW_W + 1;               // filter sum
  localparam int unsigned R_W     = Y_W - 16;               // filter sum after rounding

  // bias division by reciprocal multiply, one reciprocal chunk per step
  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned RCP_C     = 13;                   // reciprocal chunk width
  localparam int unsigned RCP_S     = DIV_STEPS * RCP_C;    // reciprocal scale shift
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);    // division step count

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOOL_WEIGHT  = 3'd0,
    CFG_COM_OFFSET_X = 3'd1,
    CFG_COM_OFFSET_Y = 3'd2,
    CFG_COM_OFFSET_Z = 3'd3,
    CFG_FILTER_GAIN  = 3'd4
  } cfg_reg_e;

  // register reset values
  localparam logic [WEIGHT_W-1:0]     TOOL_WEIGHT_RST = 25'd51414;
  localparam logic signed [COM_W-1:0] COM_X_RST       = 18'sd0;
  localparam logic signed [COM_W-1:0] COM_Y_RST       = 18'sd0;
  localparam logic signed [COM_W-1:0] COM_Z_RST       = 18'sd1311;
  localparam logic [GAIN_W-1:0]       FILTER_GAIN_RST = 16'd58982;

  // per-cycle commands from the sequencer to every lane
  typedef struct packed {
    logic              acc_en;    // add raw minus load into the bias sum
    logic              div_load;  // load the division from the bias sum
    logic              div_step;  // one reciprocal chunk
    logic [DCNT_W-1:0] div_idx;   // which reciprocal chunk, lowest first
    logic              div_end;   // write the rounded bias back
    logic              mul_en;    // register the filter products
    logic              filt_en;   // update the filter state
  } lane_ctrl_t;

endpackage

FILE: rtl/wbgc_load.sv
// wbgc_load: three-stage pipeline that forms the tool load wrench
// (force = -weight * axis, torque = offset x force). Uses wbgc_pkg.
module wbgc_load import wbgc_pkg::*; (
  input  logic                        clk_i,
  input  logic        [WEIGHT_W-1:0]  weight_i,
  input  logic signed [COM_W-1:0]     com_i  [NUM_AXIS],
  input  logic signed [AXIS_W-1:0]    axis_i [NUM_AXIS],
  output logic signed [LD_W-1:0]      ld_o   [NUM_LANES]
);

  logic signed [F_W-1:0]     f_q  [NUM_AXIS];
  logic signed [F_W-1:0]     f_d  [NUM_AXIS];
  logic signed [XP_W-1:0]    xp_q [NUM_LANES];
  logic signed [XP_W-1:0]    xp_d [NUM_LANES];
  logic signed [LD_W-1:0]    tq_q [NUM_AXIS];
  logic signed [LD_W-1:0]    tq_d [NUM_AXIS];
  logic signed [FPROD_W-1:0] fprod [NUM_AXIS];
  logic signed [FPROD_W-1:0] fround [NUM_AXIS];
  logic signed [XP_W:0]      tdiff [NUM_AXIS];

  // load force, rounded half up from Q30 to Q16.16
  always_comb begin
    for (int i = 0; i < NUM_AXIS; i++) begin
      fprod[i]  = $signed({1'b0, weight_i}) * axis_i[i];
      fround[i] = -fprod[i] + FPROD_W'(signed'(8192));
      f_d[i]    = fround[i][FPROD_W-1:14];
    end
  end

  // cross product terms, ordered c1*f2, c2*f1, c2*f0, c0*f2, c0*f1, c1*f0
  always_comb begin
    xp_d[0] = com_i[1] * f_q[2];
    xp_d[1] = com_i[2] * f_q[1];
    xp_d[2] = com_i[2] * f_q[0];
    xp_d[3] = com_i[0] * f_q[2];
    xp_d[4] = com_i[0] * f_q[1];
    xp_d[5] = com_i[1] * f_q[0];
  end

  // load torque, rounded half up from Q32 to Q16.16
  always_comb begin
    for (int i = 0; i < NUM_AXIS; i++) begin
      tdiff[i] = (XP_W + 1)'(xp_q[2*i]) - (XP_W + 1)'(xp_q[2*i+1])
                 + (XP_W + 1)'(signed'(32768));
      tq_d[i]  = tdiff[i][LD_W+15:16];
    end
  end

  always_ff @(posedge clk_i) begin
    f_q  <= f_d;
    xp_q <= xp_d;
    tq_q <= tq_d;
  end

  // force then torque, all sign extended to the load width
  always_comb begin
    for (int i = 0; i < NUM_AXIS; i++) begin
      ld_o[i]            = LD_W'(f_q[i]);
      ld_o[i + NUM_AXIS] = tq_q[i];
    end
  end

endmodule

FILE: rtl/wbgc_lane.sv
// wbgc_lane: one wrench axis: bias accumulator with rounding division by a
// multi-cycle reciprocal multiply, and the exponential low-pass filter. Uses wbgc_pkg.
module wbgc_lane import wbgc_pkg::*; #(
  parameter int unsigned BIAS_SAMPLES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  logic signed [RAW_W-1:0]  raw_i,
  input  logic signed [LD_W-1:0]   ld_i,
  input  logic        [GAIN_W-1:0] gain_i,
  output logic signed [RAW_W-1:0]  filt_o
);

  localparam int unsigned HALF   = BIAS_SAMPLES / 2;
  localparam int unsigned SHIFT  = $clog2(BIAS_SAMPLES);
  localparam bit          POW2   = (BIAS_SAMPLES & (BIAS_SAMPLES - 1)) == 0;
  localparam int unsigned MUL_W  = NUM_W + RCP_C;
  localparam int unsigned PROD_W = MUL_W + 1;
  // ceil(2^RCP_S / BIAS_SAMPLES), exact floor division for numerators below 2^40
  localparam longint unsigned RECIP =
    ((64'd1 << RCP_S) + 64'(BIAS_SAMPLES) - 64'd1) / 64'(BIAS_SAMPLES);

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [RAW_W-1:0]  filt_q, filt_d;
  logic signed [ASUM_W-1:0] acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;

  logic        [NUM_W-1:0]  num_q;
  logic        [NUM_W-1:0]  quo_q, quo_d;
  logic                     neg_q;
  logic signed [NUM_W-1:0]  acc_ext;
  logic        [NUM_W-1:0]  mag;
  logic        [RCP_C-1:0]  rcp_chunk;
  logic        [MUL_W-1:0]  rcp_prod;
  logic        [PROD_W-1:0] rcp_sum;
  logic        [NUM_W-1:0]  quo;
  logic        [NUM_W-1:0]  bias;

  logic signed [W_W-1:0]    w;
  logic        [K_W-1:0]    k;
  logic signed [GY_W-1:0]   gy_q, gy_d;
  logic signed [KW_W-1:0]   kw_q, kw_d;
  logic signed [Y_W-1:0]    y;
  logic signed [R_W-1:0]    r;
  logic signed [RAW_W-1:0]  r_sat;

  // bias sum update, saturated to the accumulator width
  always_comb begin
    acc_sum = ASUM_W'(acc_q) + ASUM_W'(raw_i) - ASUM_W'(ld_i);
    if (acc_sum[ASUM_W-1:ACC_W-1] != '0 && acc_sum[ASUM_W-1:ACC_W-1] != '1) begin
      acc_sat = acc_sum[ASUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                  : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  // division: magnitude plus half the divisor times the reciprocal,
  // one chunk a step from the lowest, keeping only the bits above each chunk
  always_comb begin
    acc_ext   = NUM_W'(acc_q);
    mag       = acc_q[ACC_W-1] ? -acc_ext : acc_ext;
    rcp_chunk = RCP_C'(RECIP >> (RCP_C * ctrl_i.div_idx));
    rcp_prod  = MUL_W'(num_q) * MUL_W'(rcp_chunk);
    rcp_sum   = PROD_W'(quo_q) + PROD_W'(rcp_prod);
    quo_d     = rcp_sum[RCP_C +: NUM_W];
    quo       = POW2 ? (num_q >> SHIFT) : quo_q;
    bias      = neg_q ? -quo : quo;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      num_q <= mag + NUM_W'(HALF);
      quo_q <= '0;
      neg_q <= acc_q[ACC_W-1];
    end else if (ctrl_i.div_step) begin
      quo_q <= quo_d;
    end
  end

  // filter products: g*y and (65536-g)*w
  always_comb begin
    w    = W_W'(raw_i) - W_W'(acc_q) - W_W'(ld_i);
    k    = K_W'(17'h10000) - K_W'(gain_i);
    gy_d = $signed({1'b0, gain_i}) * filt_q;
    kw_d = $signed({1'b0, k}) * w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      gy_q <= gy_d;
      kw_q <= kw_d;
    end
  end

  // round half up, then saturate to 32 bits
  always_comb begin
    y = Y_W'(gy_q) + Y_W'(kw_q) + Y_W'(signed'(32768));
    r = y[Y_W-1:16];
    if (r[R_W-1:RAW_W-1] != '0 && r[R_W-1:RAW_W-1] != '1) begin
      r_sat = r[R_W-1] ? {1'b1, {(RAW_W-1){1'b0}}} : {1'b0, {(RAW_W-1){1'b1}}};
    end else begin
      r_sat = r[RAW_W-1:0];
    end
  end

  // next bias sum and filter state
  always_comb begin
    acc_d  = acc_q;
    filt_d = filt_q;
    if (ctrl_i.acc_en) begin
      acc_d = acc_sat;
    end else if (ctrl_i.div_end) begin
      acc_d = bias[ACC_W-1:0];
    end
    if (ctrl_i.filt_en) begin
      filt_d = r_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      filt_q <= '0;
    end else begin
      acc_q  <= acc_d;
      filt_q <= filt_d;
    end
  end

  assign filt_o = filt_q;

endmodule

FILE: rtl/wbgc_merge.sv
// wbgc_merge: output register that gathers the six lane results and the
// calibrated flag into one result transfer. Uses wbgc_pkg.
module wbgc_merge import wbgc_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           calib_i,
  input  logic signed [RAW_W-1:0]        filt_i [NUM_LANES],
  input  logic                           m_axis_tready_i,
  output logic                           m_axis_tvalid_o,
  output logic [NUM_LANES*RAW_W-1:0]     m_axis_tdata_o,
  output logic                           m_axis_tuser_o,
  output logic                           free_o
);

  logic                         valid_q, valid_d;
  logic [NUM_LANES*RAW_W-1:0]   data_q, data_d;
  logic                         user_q;

  // pack lanes, lane 0 in the lowest bits
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      data_d[i*RAW_W +: RAW_W] = filt_i[i];
    end
  end

  assign free_o = !valid_q || m_axis_tready_i;

  // valid set on load, cleared when the transfer completes
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
      user_q <= calib_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;

endmodule

FILE: rtl/wrench_bias_gravity_comp_filter_unit.sv
// wrench_bias_gravity_comp_filter_unit: top level with configuration
// registers and item sequencer. Uses wbgc_pkg, wbgc_load, wbgc_lane, wbgc_merge.
//
// Usage:
//  Input stream s_axis_*: one raw six-axis wrench, the vertical axis in
//  sensor frame, and the pose-valid flag in tuser. Output stream m_axis_*:
//  the filtered wrench and the calibrated flag in tuser, one result per item.
//  Config channel cfg_*: register index and data, always ready; write only
//  while no item is in flight.
//  Sequence: an item with pose invalid goes straight to the output register;
//  otherwise it passes the three-stage load wrench pipeline and the
//  accumulate step, and once calibrated also the two-stage filter multiply in
//  the lanes. The sample that completes calibration first runs the rounding
//  division in each lane, a multiply by the reciprocal of the sample count.
//  Input is taken only between items; the output register holds a finished
//  result so the next item starts while the receiver stalls, and the item
//  after that waits at the output until the result is taken.
//  Reset: bias sum, sample count, calibrated flag and filter state clear;
//  registers return to their defaults; no result is pending.
module wrench_bias_gravity_comp_filter_unit import wbgc_pkg::*; #(
  parameter int unsigned BIAS_SAMPLES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z (32 bit each),
  // up_axis_x, up_axis_y, up_axis_z (16 bit each)
  input  logic [NUM_LANES*RAW_W+NUM_AXIS*AXIS_W-1:0] s_axis_tdata_i,
  // pose_valid
  input  logic                          s_axis_tuser_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // filt_force_x, filt_force_y, filt_force_z, filt_torque_x, filt_torque_y,
  // filt_torque_z (32 bit each)
  output logic [NUM_LANES*RAW_W-1:0]    m_axis_tdata_o,
  // calibrated
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_addr_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(BIAS_SAMPLES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LF, S_LX, S_LT, S_ACC, S_DLD, S_DIV, S_DEND, S_FMUL, S_FADD, S_OUT
  } state_e;

  state_e                      state_q;
  logic [CNT_W-1:0]            count_q;
  logic [CNT_W-1:0]            count_inc;
  logic                        ready_q;
  logic [DCNT_W-1:0]           div_cnt_q;

  logic        [WEIGHT_W-1:0]  weight_q;
  logic signed [COM_W-1:0]     com_q  [NUM_AXIS];
  logic        [GAIN_W-1:0]    gain_q;

  logic signed [RAW_W-1:0]     raw_q  [NUM_LANES];
  logic signed [AXIS_W-1:0]    axis_q [NUM_AXIS];
  logic signed [LD_W-1:0]      ld     [NUM_LANES];
  logic signed [RAW_W-1:0]     filt   [NUM_LANES];

  lane_ctrl_t                  ctrl;
  logic                        in_xfer;
  logic                        out_free;
  logic                        out_load;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign count_inc       = CNT_W'(count_q + 1'b1);
  assign out_load        = (state_q == S_OUT) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= TOOL_WEIGHT_RST;
      com_q[0] <= COM_X_RST;
      com_q[1] <= COM_Y_RST;
      com_q[2] <= COM_Z_RST;
      gain_q   <= FILTER_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_TOOL_WEIGHT:  weight_q <= cfg_data_i[WEIGHT_W-1:0];
        CFG_COM_OFFSET_X: com_q[0] <= cfg_data_i[COM_W-1:0];
        CFG_COM_OFFSET_Y: com_q[1] <= cfg_data_i[COM_W-1:0];
        CFG_COM_OFFSET_Z: com_q[2] <= cfg_data_i[COM_W-1:0];
        CFG_FILTER_GAIN:  gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the input item on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        raw_q[i] <= s_axis_tdata_i[i*RAW_W +: RAW_W];
      end
      for (int j = 0; j < NUM_AXIS; j++) begin
        axis_q[j] <= s_axis_tdata_i[NUM_LANES*RAW_W + j*AXIS_W +: AXIS_W];
      end
    end
  end

  // lane commands decoded from the sequencer state
  always_comb begin
    ctrl          = '0;
    ctrl.acc_en   = (state_q == S_ACC) && !ready_q;
    ctrl.div_load = (state_q == S_DLD);
    ctrl.div_step = (state_q == S_DIV);
    ctrl.div_idx  = div_cnt_q;
    ctrl.div_end  = (state_q == S_DEND);
    ctrl.mul_en   = (state_q == S_FMUL);
    ctrl.filt_en  = (state_q == S_FADD);
  end

  // item sequencer, sample count and calibrated flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ready_q   <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= s_axis_tuser_i ? S_LF : S_OUT;
          end
        end
        S_LF: state_q <= S_LX;
        S_LX: state_q <= S_LT;
        S_LT: state_q <= S_ACC;
        S_ACC: begin
          if (ready_q) begin
            state_q <= S_FMUL;
          end else begin
            count_q <= count_inc;
            state_q <= (count_inc == CNT_W'(BIAS_SAMPLES)) ? S_DLD : S_OUT;
          end
        end
        S_DLD: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_q <= DCNT_W'(div_cnt_q + 1'b1);
          if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_DEND;
          end
        end
        S_DEND: begin
          ready_q <= 1'b1;
          state_q <= S_FMUL;
        end
        S_FMUL: state_q <= S_FADD;
        S_FADD: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // load wrench pipeline
  wbgc_load u_load (
    .clk_i    (clk_i),
    .weight_i (weight_q),
    .com_i    (com_q),
    .axis_i   (axis_q),
    .ld_o     (ld)
  );

  // one lane per wrench axis
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    wbgc_lane #(
      .BIAS_SAMPLES (BIAS_SAMPLES)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .raw_i  (raw_q[g]),
      .ld_i   (ld[g]),
      .gain_i (gain_q),
      .filt_o (filt[g])
    );
  end

  // result register
  wbgc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_load),
    .calib_i         (ready_q),
    .filt_i          (filt),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .free_o          (out_free)
  );

endmodule
